FILE: rtl/dcwg_pkg.sv
`timescale 1ns / 1ps

package dcwg_pkg;

  // configuration register set is fixed at two channels
  localparam int unsigned CFG_CH  = 2;
  localparam int unsigned CFG_AW  = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned WAVE_W  = 3;
  localparam int unsigned STEP_W  = 32;
  localparam int unsigned ATT_W   = 16;
  localparam int unsigned SMP_W   = 12;

  // multiplier: A = 4095*att, att for sine (unsigned); B signed wave term
  localparam int unsigned A_W     = 28;
  localparam int unsigned B_W     = 18;
  localparam int unsigned PROD_W  = A_W + 1 + B_W;

  // output queue
  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned OUT_AW    = 3;
  localparam int unsigned OUT_CW    = 4;

  localparam logic [SMP_W-1:0]  MID_CODE    = 12'd2048;
  localparam logic [SMP_W-1:0]  MAX_CODE    = 12'd4095;
  localparam logic [WAVE_W-1:0] WAVE_RESET  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_RESET  = 32'd21474836;
  localparam logic [ATT_W-1:0]  ATTEN_RESET = 16'd64880;

  typedef enum logic [2:0] {
    REG_WAVE_A  = 3'd0,
    REG_WAVE_B  = 3'd1,
    REG_STEP_A  = 3'd2,
    REG_STEP_B  = 3'd3,
    REG_ATTEN_A = 3'd4,
    REG_ATTEN_B = 3'd5
  } dcwg_reg_e;

  typedef enum logic [WAVE_W-1:0] {
    WAVE_SINE   = 3'd0,
    WAVE_RISE   = 3'd1,
    WAVE_FALL   = 3'd2,
    WAVE_TRI    = 3'd3,
    WAVE_SQUARE = 3'd4
  } dcwg_wave_e;

  typedef enum logic [1:0] {
    SHIFT_17 = 2'd0,
    SHIFT_20 = 2'd1,
    SHIFT_32 = 2'd2,
    SHIFT_33 = 2'd3
  } dcwg_shift_e;

  typedef struct packed {
    logic [CFG_CH-1:0][WAVE_W-1:0] wave_kind;
    logic [CFG_CH-1:0][STEP_W-1:0] phase_step;
    logic [CFG_CH-1:0][ATT_W-1:0]  attenuation;
  } dcwg_cfg_t;

  // sin(pi/2 * k / 2^qb) in Q1.15, odd polynomial in Q30; elaboration only
  function automatic logic [15:0] quarter_sine(input logic [63:0] k, input int unsigned qb);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] s;
    logic [63:0] r;
    x = k << (30 - qb);
    y = (x * x) >> 30;
    s = 64'd3864;
    s = 64'd172272 - ((y * s) >> 30);
    s = 64'd5026995 - ((y * s) >> 30);
    s = 64'd85569306 - ((y * s) >> 30);
    s = 64'd693598668 - ((y * s) >> 30);
    s = 64'd1686629713 - ((y * s) >> 30);
    s = (x * s) >> 30;
    r = (s * 64'd32768 + (64'd1 << 29)) >> 30;
    if (r > 64'd32768) begin
      r = 64'd32768;
    end
    return r[15:0];
  endfunction

endpackage

FILE: rtl/dcwg_cfg_regs.sv
`timescale 1ns / 1ps

module dcwg_cfg_regs import dcwg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output dcwg_cfg_t         cfg_o
);

  dcwg_cfg_t cfg_q;
  dcwg_reg_e reg_sel;
  logic      wr_en;

  assign reg_sel = dcwg_reg_e'(paddr[CFG_AW-1:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wave_kind   <= {CFG_CH{WAVE_RESET}};
      cfg_q.phase_step  <= {CFG_CH{STEP_RESET}};
      cfg_q.attenuation <= {CFG_CH{ATTEN_RESET}};
    end else if (wr_en) begin
      case (reg_sel)
        REG_WAVE_A:  cfg_q.wave_kind[0]   <= pwdata[WAVE_W-1:0];
        REG_WAVE_B:  cfg_q.wave_kind[1]   <= pwdata[WAVE_W-1:0];
        REG_STEP_A:  cfg_q.phase_step[0]  <= pwdata[STEP_W-1:0];
        REG_STEP_B:  cfg_q.phase_step[1]  <= pwdata[STEP_W-1:0];
        REG_ATTEN_A: cfg_q.attenuation[0] <= pwdata[ATT_W-1:0];
        REG_ATTEN_B: cfg_q.attenuation[1] <= pwdata[ATT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_WAVE_A:  prdata = DATA_W'(cfg_q.wave_kind[0]);
      REG_WAVE_B:  prdata = DATA_W'(cfg_q.wave_kind[1]);
      REG_STEP_A:  prdata = DATA_W'(cfg_q.phase_step[0]);
      REG_STEP_B:  prdata = DATA_W'(cfg_q.phase_step[1]);
      REG_ATTEN_A: prdata = DATA_W'(cfg_q.attenuation[0]);
      REG_ATTEN_B: prdata = DATA_W'(cfg_q.attenuation[1]);
      default:     prdata = '0;
    endcase
  end

endmodule

FILE: rtl/dcwg_phase_ram.sv
`timescale 1ns / 1ps

module dcwg_phase_ram #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned AW    = 1,
  parameter int unsigned W     = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [AW-1:0] rd_addr_i,
  output logic [W-1:0]  rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [W-1:0]  wr_data_i
);

  logic [W-1:0]     mem [DEPTH];
  logic [W-1:0]     rd_q;
  logic [DEPTH-1:0] vld_q;
  logic             rd_vld_q;

  // read-before-write: a same-edge write is not seen by the read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  // entries never written read as zero phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

FILE: rtl/dcwg_sine_rom.sv
`timescale 1ns / 1ps

module dcwg_sine_rom import dcwg_pkg::*; #(
  parameter int unsigned QB = 8
) (
  input  logic          clk_i,
  input  logic [QB-1:0] addr_i,
  output logic [15:0]   data_o
);

  localparam int unsigned DEPTH = 1 << QB;

  logic [15:0] rom_tbl [DEPTH];
  logic [15:0] rd_q;

  for (genvar k = 0; k < DEPTH; k++) begin : g_tbl
    localparam logic [15:0] ENTRY = quarter_sine(64'(k), QB);
    assign rom_tbl[k] = ENTRY;
  end

  always_ff @(posedge clk_i) begin
    rd_q <= rom_tbl[addr_i];
  end

  assign data_o = rd_q;

endmodule

FILE: rtl/dual_channel_waveform_generator_top.sv
// Two-channel DDS waveform generator.
// Request channel: in_valid_i / in_stall_o with channel_i. Each item asks for
// the next sample of that channel; the channel's phase then advances by its
// step. Result channel: out_valid_o / out_stall_i with sample_o (12-bit DAC
// code) and sample_channel_o, one result per item, in request order.
// Config: APB-style port, registers at 4*i: wave type a/b, phase step a/b,
// attenuation a/b. Write only while no items are in flight.
// Throughput: one item per clock while in_stall_o is low. The phase RAM is read
// at accept and written back in the following cycle; a same-channel request in
// the next cycle takes the written-back phase from a forwarding register.
// Pipeline: phase read at accept, ROM read, multiply, scale/saturate into an
// 8-entry output queue; out_valid_o rises once the result is queued, and the
// result can be taken from then on.
// Stall: results wait in the queue; in_stall_o rises once 8 items are
// outstanding (in the pipe or queued), so no item is ever dropped.
// Reset: all phases read as zero, registers return to their defaults, the
// queue empties. No clearing pass is needed.
`timescale 1ns / 1ps

module dual_channel_waveform_generator_top import dcwg_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = 10,
  parameter int unsigned NUM_CHANNELS    = 2,
  parameter int unsigned PHASE_BITS      = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              channel_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SMP_W-1:0]  sample_o,
  output logic              sample_channel_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int unsigned QB    = SINE_TABLE_BITS - 2;
  localparam int unsigned CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  dcwg_cfg_t cfg;

  logic in_accept;
  logic out_take;

  // stage 1: phase available
  logic                  s1_valid_q;
  logic                  s1_ch_q;
  logic [PHASE_BITS-1:0] ram_rd_data;
  logic                  fwd_valid_q;
  logic [CH_AW-1:0]      fwd_addr_q;
  logic [PHASE_BITS-1:0] fwd_phase_q;

  logic                  ch_ok;
  logic [CH_AW-1:0]      ch_addr;
  logic [PHASE_BITS-1:0] phase;
  logic [15:0]           p16;
  logic [1:0]            quad;
  logic [QB-1:0]         rem;
  logic [QB-1:0]         rom_addr;
  logic                  rom_full;
  logic                  rom_neg;
  dcwg_wave_e            wave;
  logic [ATT_W-1:0]      att;
  logic [A_W-1:0]        m_scale;
  logic [17:0]           ramp2;
  logic [17:0]           tri_t;
  logic [A_W-1:0]        a_d;
  logic signed [B_W-1:0] b_d;
  logic                  sine_d;
  dcwg_shift_e           sh_d;
  logic                  known;
  logic                  wr_en;
  logic [PHASE_BITS-1:0] wr_phase;

  // stage 2: ROM data, multiply
  logic                  s2_valid_q;
  logic                  s2_ch_q;
  logic                  s2_sine_q;
  logic                  s2_neg_q;
  logic                  s2_full_q;
  dcwg_shift_e           s2_sh_q;
  logic [A_W-1:0]        s2_a_q;
  logic signed [B_W-1:0] s2_b_q;
  logic [15:0]           rom_data;
  logic [15:0]           sine_mag;
  logic signed [B_W-1:0] sine_b;
  logic signed [B_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_d;

  // stage 3: scale and saturate
  logic                     s3_valid_q;
  logic                     s3_ch_q;
  dcwg_shift_e              s3_sh_q;
  logic signed [PROD_W-1:0] s3_prod_q;
  logic signed [PROD_W-1:0] shifted;
  logic signed [PROD_W-1:0] level;
  logic [SMP_W-1:0]         sample_d;

  // output queue
  logic [SMP_W-1:0]  fifo_smp_q [OUT_DEPTH];
  logic              fifo_ch_q  [OUT_DEPTH];
  logic [OUT_AW-1:0] wr_ptr_q;
  logic [OUT_AW-1:0] rd_ptr_q;
  logic [OUT_CW-1:0] fifo_cnt_q;
  logic [OUT_CW-1:0] fifo_cnt_d;
  logic [OUT_CW-1:0] outstanding_q;
  logic [OUT_CW-1:0] outstanding_d;

  dcwg_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_stall_o  = (outstanding_q == OUT_CW'(OUT_DEPTH));
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_valid_o = (fifo_cnt_q != '0);
  assign out_take    = out_valid_o & ~out_stall_i;

  dcwg_phase_ram #(
    .DEPTH (NUM_CHANNELS),
    .AW    (CH_AW),
    .W     (PHASE_BITS)
  ) u_phase_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (CH_AW'(channel_i)),
    .rd_data_o (ram_rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (ch_addr),
    .wr_data_i (wr_phase)
  );

  // ---------------- stage 1 ----------------
  assign ch_ok   = (32'(s1_ch_q) < NUM_CHANNELS);
  assign ch_addr = CH_AW'(s1_ch_q);
  assign phase   = (fwd_valid_q && fwd_addr_q == ch_addr) ? fwd_phase_q : ram_rd_data;
  assign p16     = phase[PHASE_BITS-1 -: 16];
  assign quad    = phase[PHASE_BITS-1 -: 2];
  assign rem     = phase[PHASE_BITS-3 -: QB];

  // negated cosine from the quarter table: even quadrants mirror the index
  assign rom_addr = quad[0] ? rem : (~rem + 1'b1);
  assign rom_full = ~quad[0] && (rem == '0);
  assign rom_neg  = quad[1] ^ quad[0];

  assign wave    = dcwg_wave_e'(cfg.wave_kind[s1_ch_q]);
  assign att     = cfg.attenuation[s1_ch_q];
  assign m_scale = {att, 12'b0} - A_W'(att);
  assign ramp2   = {1'b0, p16, 1'b0};
  assign tri_t   = p16[15] ? (18'd131072 - ramp2) : ramp2;

  always_comb begin
    a_d    = '0;
    b_d    = '0;
    sine_d = 1'b0;
    sh_d   = SHIFT_17;
    known  = 1'b1;
    case (wave)
      WAVE_SINE: begin
        a_d    = A_W'(att);
        sine_d = 1'b1;
        sh_d   = SHIFT_20;
      end
      WAVE_RISE: begin
        a_d  = m_scale;
        b_d  = $signed(ramp2) - 18'sd65536;
        sh_d = SHIFT_33;
      end
      WAVE_FALL: begin
        a_d  = m_scale;
        b_d  = 18'sd65536 - $signed(ramp2);
        sh_d = SHIFT_33;
      end
      WAVE_TRI: begin
        a_d  = m_scale;
        b_d  = $signed(tri_t) - 18'sd32768;
        sh_d = SHIFT_32;
      end
      WAVE_SQUARE: begin
        a_d  = m_scale;
        b_d  = phase[PHASE_BITS-1] ? -18'sd1 : 18'sd1;
        sh_d = SHIFT_17;
      end
      default: begin
        known = 1'b0;
      end
    endcase
    // zero product leaves the sample at mid-scale
    if (!ch_ok || !known) begin
      a_d    = '0;
      b_d    = '0;
      sine_d = 1'b0;
    end
  end

  assign wr_en    = s1_valid_q & ch_ok & known;
  assign wr_phase = phase + PHASE_BITS'(cfg.phase_step[s1_ch_q]);

  dcwg_sine_rom #(
    .QB (QB)
  ) u_sine_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // ---------------- stage 2 ----------------
  assign sine_mag = s2_full_q ? 16'h8000 : rom_data;
  assign sine_b   = s2_neg_q ? $signed({2'b0, sine_mag}) : -$signed({2'b0, sine_mag});
  assign mul_b    = s2_sine_q ? sine_b : s2_b_q;
  assign prod_d   = $signed({1'b0, s2_a_q}) * mul_b;

  // ---------------- stage 3 ----------------
  always_comb begin
    case (s3_sh_q)
      SHIFT_17: shifted = s3_prod_q >>> 17;
      SHIFT_20: shifted = s3_prod_q >>> 20;
      SHIFT_32: shifted = s3_prod_q >>> 32;
      SHIFT_33: shifted = s3_prod_q >>> 33;
      default:  shifted = s3_prod_q >>> 17;
    endcase
  end

  assign level = shifted + $signed({{(PROD_W-SMP_W){1'b0}}, MID_CODE});

  always_comb begin
    if (level[PROD_W-1]) begin
      sample_d = '0;
    end else if (level > $signed({{(PROD_W-SMP_W){1'b0}}, MAX_CODE})) begin
      sample_d = MAX_CODE;
    end else begin
      sample_d = level[SMP_W-1:0];
    end
  end

  // ---------------- queue bookkeeping ----------------
  always_comb begin
    outstanding_d = outstanding_q;
    if (in_accept && !out_take) begin
      outstanding_d = outstanding_q + 1'b1;
    end else if (!in_accept && out_take) begin
      outstanding_d = outstanding_q - 1'b1;
    end
    fifo_cnt_d = fifo_cnt_q;
    if (s3_valid_q && !out_take) begin
      fifo_cnt_d = fifo_cnt_q + 1'b1;
    end else if (!s3_valid_q && out_take) begin
      fifo_cnt_d = fifo_cnt_q - 1'b1;
    end
  end

  assign sample_o         = fifo_smp_q[rd_ptr_q];
  assign sample_channel_o = fifo_ch_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      s2_valid_q    <= 1'b0;
      s3_valid_q    <= 1'b0;
      fwd_valid_q   <= 1'b0;
      wr_ptr_q      <= '0;
      rd_ptr_q      <= '0;
      fifo_cnt_q    <= '0;
      outstanding_q <= '0;
    end else begin
      s1_valid_q    <= in_accept;
      s2_valid_q    <= s1_valid_q;
      s3_valid_q    <= s2_valid_q;
      fwd_valid_q   <= wr_en;
      fifo_cnt_q    <= fifo_cnt_d;
      outstanding_q <= outstanding_d;
      if (s3_valid_q) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (out_take) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ch_q     <= channel_i;
    fwd_addr_q  <= ch_addr;
    fwd_phase_q <= wr_phase;
    s2_ch_q     <= s1_ch_q;
    s2_sine_q   <= sine_d;
    s2_neg_q    <= rom_neg;
    s2_full_q   <= rom_full;
    s2_sh_q     <= sh_d;
    s2_a_q      <= a_d;
    s2_b_q      <= b_d;
    s3_ch_q     <= s2_ch_q;
    s3_sh_q     <= s2_sh_q;
    s3_prod_q   <= prod_d;
    if (s3_valid_q) begin
      fifo_smp_q[wr_ptr_q] <= sample_d;
      fifo_ch_q[wr_ptr_q]  <= s3_ch_q;
    end
  end

  // ---------------- assertions ----------------
  a_outstanding_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding_q <= OUT_CW'(OUT_DEPTH))
    else $error("outstanding item count above queue depth");

  a_queue_within_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= outstanding_q)
    else $error("queued results exceed outstanding items");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> (fifo_cnt_q < OUT_CW'(OUT_DEPTH)))
    else $error("result pushed into a full output queue");

  a_writeback_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> $past(in_accept))
    else $error("phase write-back without a request in the previous cycle");

endmodule
